### rtl/core/cfb_pkg.sv
// Shared types and constants of the command frame builder.
// No dependencies; used by every module of the block.
package cfb_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] MAX_LEN_RESET = 8'd59;
    localparam logic [7:0] SYNC_RESET    = 8'hA5;

    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_MAX_LEN = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_SYNC    = 3'd4;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // what the back end must emit for one accepted item
    typedef enum logic [2:0] {
        K_REJECT,
        K_HDR,
        K_HDR_CLOSE,
        K_PAY,
        K_PAY_CLOSE
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] csum;
    } job_t;

endpackage

### rtl/core/command_frame_builder_top.sv
// Top level of the command frame builder: config registers, front end, queue, back end.
// Depends on cfb_pkg, cfb_front, cfb_queue, cfb_back.
//
// Usage:
//   Input words are pushed with push while full is low. A header word (opcode 0)
//   gives command, chunk_index and payload_len; payload words (opcode 1) carry
//   payload_byte. Output words are taken with pop while empty is low; each
//   carries out_byte, frame_last (checksum word) and rejected (over-length header).
//   A header yields four words (five when payload_len is zero), a payload word one
//   (two for the last byte of a frame), a rejected header one word.
//   The first output word passes through the job queue, then the output register.
//   Throughput: one input word per cycle while full is low; one output word per cycle
//   while pop is high, from the back end draining a QUEUE_DEPTH-entry job queue.
//   When pop stays low the output register holds, the queue fills and full rises.
//   Reset clears frame state, queue and output; config returns to length 59 and
//   sync byte 0xA5. Users must write config through the APB port while idle (unenforced).
module command_frame_builder_top
#(
    parameter int unsigned QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        opcode,
    input  logic [7:0]                  command,
    input  logic [7:0]                  chunk_index,
    input  logic [7:0]                  payload_len,
    input  logic [7:0]                  payload_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  out_byte,
    output logic                        frame_last,
    output logic                        rejected,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfb_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [7:0]    max_len_reg;
    logic [7:0]    sync_reg;
    logic          cfg_wr;
    logic          accept;
    logic          job_push;
    cfb_pkg::job_t front_job;
    logic          q_empty;
    logic          q_pop;
    cfb_pkg::job_t head_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= cfb_pkg::MAX_LEN_RESET;
            sync_reg    <= cfb_pkg::SYNC_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr == cfb_pkg::ADDR_MAX_LEN)
                max_len_reg <= pwdata[7:0];
            else if (paddr == cfb_pkg::ADDR_SYNC)
                sync_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == cfb_pkg::ADDR_MAX_LEN)
            prdata = {24'd0, max_len_reg};
        else if (paddr == cfb_pkg::ADDR_SYNC)
            prdata = {24'd0, sync_reg};
    end

    assign accept = push && !full;

    cfb_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .opcode          (opcode),
        .command         (command),
        .chunk_index     (chunk_index),
        .payload_len     (payload_len),
        .payload_byte    (payload_byte),
        .max_payload_len (max_len_reg),
        .sync_byte       (sync_reg),
        .job_push        (job_push),
        .job             (front_job)
    );

    cfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (front_job),
        .pop      (q_pop),
        .full     (full),
        .empty    (q_empty),
        .head_job (head_job)
    );

    cfb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_empty  (q_empty),
        .job        (head_job),
        .job_pop    (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .frame_last (frame_last),
        .rejected   (rejected)
    );

`ifndef NO_ASSERTIONS
    a_rej_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rejected) |-> (!frame_last && out_byte == 8'd0))
        else $error("rejected word carries frame data");

    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !q_empty)
        else $error("queue full while empty");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !empty)
        else $error("job retired without output word");
`endif

endmodule

### rtl/core/cfb_front.sv
// Front end: accepts input words, tracks frame state, builds one job per item.
// Depends on cfb_pkg.
module cfb_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                opcode,
    input  logic [7:0]          command,
    input  logic [7:0]          chunk_index,
    input  logic [7:0]          payload_len,
    input  logic [7:0]          payload_byte,
    input  logic [7:0]          max_payload_len,
    input  logic [7:0]          sync_byte,
    output logic                job_push,
    output cfb_pkg::job_t       job
);

    logic       in_frame_reg, in_frame_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] hdr_sum;
    logic [7:0] pay_sum;

    assign hdr_sum = sync_byte + command + chunk_index + payload_len;
    assign pay_sum = sum_reg + payload_byte;

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        job_push       = 1'b0;
        job.kind       = cfb_pkg::K_PAY;
        job.b0         = payload_byte;
        job.b1         = command;
        job.b2         = chunk_index;
        job.b3         = payload_len;
        job.csum       = 8'd0 - pay_sum;
        if (accept)
        begin
            if (opcode == cfb_pkg::OP_HEADER)
            begin
                job_push = 1'b1;
                job.b0   = sync_byte;
                job.csum = 8'd0 - hdr_sum;
                if (payload_len > max_payload_len)
                begin
                    job.kind = cfb_pkg::K_REJECT;
                end
                else
                begin
                    sum_next = hdr_sum;
                    if (payload_len == 8'd0)
                    begin
                        job.kind       = cfb_pkg::K_HDR_CLOSE;
                        in_frame_next  = 1'b0;
                        remaining_next = 8'd0;
                    end
                    else
                    begin
                        job.kind       = cfb_pkg::K_HDR;
                        in_frame_next  = 1'b1;
                        remaining_next = payload_len;
                    end
                end
            end
            else if (in_frame_reg)
            begin
                job_push = 1'b1;
                sum_next = pay_sum;
                if (remaining_reg == 8'd1)
                begin
                    job.kind       = cfb_pkg::K_PAY_CLOSE;
                    in_frame_next  = 1'b0;
                    remaining_next = 8'd0;
                end
                else
                begin
                    job.kind       = cfb_pkg::K_PAY;
                    remaining_next = remaining_reg - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            remaining_reg <= 8'd0;
            sum_reg       <= 8'd0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
        end
    end

endmodule

### rtl/core/cfb_queue.sv
// Short job queue between front and back ends, register based.
// Depends on cfb_pkg.
module cfb_queue
#(
    parameter int unsigned DEPTH = cfb_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cfb_pkg::job_t       push_job,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output cfb_pkg::job_t       head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cfb_pkg::job_t    store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/cfb_back.sv
// Back end: expands jobs into output register words, one per cycle unless pop stalls.
// Depends on cfb_pkg.
module cfb_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    input  cfb_pkg::job_t       job,
    output logic                job_pop,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic                frame_last,
    output logic                rejected
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       rej_reg;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] last_idx;
    logic [7:0] sel_byte;
    logic       sel_last;
    logic       sel_rej;
    logic       advance;
    logic       take;

    always_comb
    begin
        sel_byte = job.b0;
        sel_last = 1'b0;
        sel_rej  = 1'b0;
        last_idx = 3'd0;
        unique case (job.kind)
            cfb_pkg::K_REJECT:
            begin
                sel_byte = 8'd0;
                sel_rej  = 1'b1;
            end
            cfb_pkg::K_HDR, cfb_pkg::K_HDR_CLOSE:
            begin
                last_idx = (job.kind == cfb_pkg::K_HDR) ? 3'd3 : 3'd4;
                unique case (idx_reg)
                    3'd0:    sel_byte = job.b0;
                    3'd1:    sel_byte = job.b1;
                    3'd2:    sel_byte = job.b2;
                    3'd3:    sel_byte = job.b3;
                    default:
                    begin
                        sel_byte = job.csum;
                        sel_last = 1'b1;
                    end
                endcase
            end
            cfb_pkg::K_PAY:
            begin
                sel_byte = job.b0;
            end
            cfb_pkg::K_PAY_CLOSE:
            begin
                last_idx = 3'd1;
                if (idx_reg != 3'd0)
                begin
                    sel_byte = job.csum;
                    sel_last = 1'b1;
                end
            end
            default:
            begin
                sel_byte = 8'd0;
            end
        endcase
    end

    assign advance = !out_valid_reg || pop;
    assign take    = advance && !job_empty;
    assign job_pop = take && (idx_reg == last_idx);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            idx_next       = job_pop ? 3'd0 : idx_reg + 3'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg <= sel_byte;
            last_reg     <= sel_last;
            rej_reg      <= sel_rej;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign frame_last = last_reg;
    assign rejected   = rej_reg;

endmodule
